/* rtl/mbcp_pkg.sv */
// ----------------------------------------------------------------------------
// mbcp_pkg
// Types and field codes shared by the mapped bearer context parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mbcp_pkg;

   // Field tags carried in field_kind
   localparam logic [2:0] KIND_IDENT   = 3'd0;
   localparam logic [2:0] KIND_LEN_HI  = 3'd1;
   localparam logic [2:0] KIND_LEN_LO  = 3'd2;
   localparam logic [2:0] KIND_FLAGS   = 3'd3;
   localparam logic [2:0] KIND_PID     = 3'd4;
   localparam logic [2:0] KIND_PLEN    = 3'd5;
   localparam logic [2:0] KIND_CONTENT = 3'd6;

   localparam logic [7:0] CONTEXT_MAX = 8'hff;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  field_kind;
      logic [7:0]  context_number;
      logic [3:0]  param_number;
      logic [3:0]  bearer_identity;
      logic [1:0]  operation_code;
      logic        e_flag;
      logic [3:0]  param_count;
      logic [15:0] context_length;
      logic [7:0]  param_identifier;
      logic [7:0]  param_length;
      logic        truncated;
   } rsp_payload_type;

   // Values latched per context and parameter
   typedef struct packed {
      logic [3:0]  bearer_identity;
      logic [1:0]  operation_code;
      logic        e_flag;
      logic [3:0]  param_count;
      logic [15:0] context_length;
      logic [7:0]  param_identifier;
      logic [7:0]  param_length;
   } latch_type;

   // Pipeline control between the stages
   typedef struct packed {
      logic valid;
      logic advance;
   } stage_ctrl_type;

endpackage

`default_nettype wire

/* rtl/mbcp_stream_if.sv */
// ----------------------------------------------------------------------------
// mbcp_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbcp_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/mbcp_in_reg.sv */
// ----------------------------------------------------------------------------
// mbcp_in_reg
// Input register: captures one byte transaction and holds it for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module mbcp_in_reg (
   input  wire logic                     clock,
   input  wire logic                     reset,
   mbcp_stream_if.sink                   req_if,
   input  wire mbcp_pkg::stage_ctrl_type ctrl,
   output      logic                     in_valid,
   output      mbcp_pkg::req_payload_type in_payload
);
   import mbcp_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   req_payload_type payload_ff;

   // Take a new byte when empty or when the held byte moves on this cycle
   assign req_if.ready = !valid_ff || ctrl.advance;
   assign valid_in     = req_if.valid || (valid_ff && !ctrl.advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         payload_ff <= req_if.payload;
      end
   end

   assign in_valid   = valid_ff;
   assign in_payload = payload_ff;

endmodule

`default_nettype wire

/* rtl/mbcp_parse_core.sv */
// ----------------------------------------------------------------------------
// mbcp_parse_core
// Parser state and the per-byte step: tags the byte and updates the latches.
// ----------------------------------------------------------------------------
`default_nettype none

module mbcp_parse_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire mbcp_pkg::stage_ctrl_type  ctrl,
   input  wire mbcp_pkg::req_payload_type in_payload,
   output      mbcp_pkg::rsp_payload_type result
);
   import mbcp_pkg::*;

   typedef enum logic [2:0] {
      PH_IDENT   = 3'd0,
      PH_LEN_HI  = 3'd1,
      PH_LEN_LO  = 3'd2,
      PH_FLAGS   = 3'd3,
      PH_PID     = 3'd4,
      PH_PLEN    = 3'd5,
      PH_CONTENT = 3'd6
   } phase_type;

   phase_type  phase_ff, phase_in, phase_nx;
   logic [7:0] ctx_count_ff, ctx_count_in, ctx_count_nx;
   logic [3:0] par_count_ff, par_count_in, par_count_nx;
   logic [3:0] par_left_ff, par_left_in, par_left_nx;
   logic [7:0] content_left_ff, content_left_in, content_left_nx;
   latch_type  latch_ff, latch_in, latch_nx;

   logic [7:0] b;
   logic [3:0] par_left_dec;
   logic [7:0] content_dec;
   logic [2:0] kind;

   assign b            = in_payload.data_byte;
   assign par_left_dec = par_left_ff - 4'd1;
   assign content_dec  = content_left_ff - 8'd1;

   always_comb begin
      phase_nx        = PH_IDENT;
      ctx_count_nx    = ctx_count_ff;
      par_count_nx    = par_count_ff;
      par_left_nx     = par_left_ff;
      content_left_nx = content_left_ff;
      latch_nx        = latch_ff;
      kind            = KIND_CONTENT;
      case (phase_ff)
         PH_IDENT: begin
            kind = KIND_IDENT;
            if (ctx_count_ff != CONTEXT_MAX) begin
               ctx_count_nx = ctx_count_ff + 8'd1;
            end
            latch_nx                 = '0;
            latch_nx.bearer_identity = b[7:4];
            par_count_nx             = '0;
            par_left_nx              = '0;
            content_left_nx          = '0;
            phase_nx                 = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            kind                    = KIND_LEN_HI;
            latch_nx.context_length = {b, 8'h00};
            phase_nx                = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            kind                         = KIND_LEN_LO;
            latch_nx.context_length[7:0] = b;
            phase_nx                     = PH_FLAGS;
         end
         PH_FLAGS: begin
            kind                    = KIND_FLAGS;
            latch_nx.operation_code = b[7:6];
            latch_nx.e_flag         = b[4];
            latch_nx.param_count    = b[3:0];
            par_left_nx             = b[3:0];
            phase_nx                = (b[3:0] != 4'd0) ? PH_PID : PH_IDENT;
         end
         PH_PID: begin
            kind                      = KIND_PID;
            par_count_nx              = par_count_ff + 4'd1;
            latch_nx.param_identifier = b;
            latch_nx.param_length     = '0;
            phase_nx                  = PH_PLEN;
         end
         PH_PLEN: begin
            kind                  = KIND_PLEN;
            latch_nx.param_length = b;
            content_left_nx       = b;
            if (b != 8'd0) begin
               phase_nx = PH_CONTENT;
            end else begin
               par_left_nx = par_left_dec;
               phase_nx    = (par_left_dec != 4'd0) ? PH_PID : PH_IDENT;
            end
         end
         default: begin
            // content bytes; unused phase codes behave the same
            kind            = KIND_CONTENT;
            content_left_nx = content_dec;
            if (content_dec != 8'd0) begin
               phase_nx = PH_CONTENT;
            end else begin
               par_left_nx = par_left_dec;
               phase_nx    = (par_left_dec != 4'd0) ? PH_PID : PH_IDENT;
            end
         end
      endcase
   end

   // Result reflects the updated latches, before any end-of-element reset
   always_comb begin
      result.field_kind       = kind;
      result.context_number   = ctx_count_nx;
      result.param_number     = par_count_nx;
      result.bearer_identity  = latch_nx.bearer_identity;
      result.operation_code   = latch_nx.operation_code;
      result.e_flag           = latch_nx.e_flag;
      result.param_count      = latch_nx.param_count;
      result.context_length   = latch_nx.context_length;
      result.param_identifier = latch_nx.param_identifier;
      result.param_length     = latch_nx.param_length;
      result.truncated        = in_payload.last_byte && (phase_nx != PH_IDENT);
   end

   // Hold unless a byte advances; drop back to the reset state after the last byte
   always_comb begin
      phase_in        = phase_ff;
      ctx_count_in    = ctx_count_ff;
      par_count_in    = par_count_ff;
      par_left_in     = par_left_ff;
      content_left_in = content_left_ff;
      latch_in        = latch_ff;
      if (ctrl.valid && ctrl.advance) begin
         if (in_payload.last_byte) begin
            phase_in        = PH_IDENT;
            ctx_count_in    = '0;
            par_count_in    = '0;
            par_left_in     = '0;
            content_left_in = '0;
            latch_in        = '0;
         end else begin
            phase_in        = phase_nx;
            ctx_count_in    = ctx_count_nx;
            par_count_in    = par_count_nx;
            par_left_in     = par_left_nx;
            content_left_in = content_left_nx;
            latch_in        = latch_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDENT;
         ctx_count_ff    <= '0;
         par_count_ff    <= '0;
         par_left_ff     <= '0;
         content_left_ff <= '0;
         latch_ff        <= '0;
      end else begin
         phase_ff        <= phase_in;
         ctx_count_ff    <= ctx_count_in;
         par_count_ff    <= par_count_in;
         par_left_ff     <= par_left_in;
         content_left_ff <= content_left_in;
         latch_ff        <= latch_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/mbcp_out_reg.sv */
// ----------------------------------------------------------------------------
// mbcp_out_reg
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mbcp_out_reg (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire mbcp_pkg::stage_ctrl_type  ctrl,
   input  wire mbcp_pkg::rsp_payload_type result,
   output      logic                      free,
   mbcp_stream_if.source                  rsp_if
);
   import mbcp_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   rsp_payload_type payload_ff;

   logic load;

   assign load     = ctrl.valid && ctrl.advance;
   assign free     = !valid_ff || rsp_if.ready;
   assign valid_in = load || (valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         payload_ff <= result;
      end
   end

   assign rsp_if.valid   = valid_ff;
   assign rsp_if.payload = payload_ff;

endmodule

`default_nettype wire

/* rtl/mapped_bearer_context_parser.sv */
// Path: an accepted byte is held in the input register, then its result is
//   loaded into the result register, from which the sink can take it.
// Throughput: one byte transaction per cycle while the sink takes results;
//   the single state update per byte in the parse core is the only loop.
// Reset: synchronous, active high; clears the parser state and both stage
//   valid flags, so the parser expects an identity byte.
// ----------------------------------------------------------------------------
// mapped_bearer_context_parser
// Tags each byte of a mapped bearer contexts element with its field and shows
// the latched context and parameter values alongside it.
// ----------------------------------------------------------------------------
`default_nettype none

module mapped_bearer_context_parser (
   input  wire logic     clock,
   input  wire logic     reset,
   mbcp_stream_if.sink   req_if,
   mbcp_stream_if.source rsp_if
);
   import mbcp_pkg::*;

   // Stage flow: input register -> parse step -> result register.
   // The held byte advances whenever the result register is empty or is
   // being drained this cycle, so bytes stream through with no bubbles.
   stage_ctrl_type  ctrl;
   logic            in_valid;
   req_payload_type in_payload;
   rsp_payload_type result;
   logic            out_free;

   assign ctrl.valid   = in_valid;
   assign ctrl.advance = in_valid && out_free;

   // Capture the incoming transaction
   mbcp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .ctrl       (ctrl),
      .in_valid   (in_valid),
      .in_payload (in_payload)
   );

   // Advance the phase machine and form the tagged result
   mbcp_parse_core u_parse_core (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .in_payload (in_payload),
      .result     (result)
   );

   // Hold the result transaction for the sink
   mbcp_out_reg u_out_reg (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .result (result),
      .free   (out_free),
      .rsp_if (rsp_if)
   );

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mapped bearer context parser: byte streams of
// well-formed, cut-short and noisy elements go in, and every tagged result is
// compared field by field with a cycle-free model of the parser state.
// ----------------------------------------------------------------------------

module tb;
   import mbcp_pkg::*;

   localparam int CLOCK_HALF   = 1;
   localparam int RESET_CYCLES = 4;
   localparam int RANDOM_BYTES = 60;
   localparam int SAT_CONTEXTS = 258;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 200000;

   // Receiver stall patterns
   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_RANDOM,
      RX_PERIODIC,
      RX_SPARSE
   } rx_pattern_type;

   logic clock;
   logic reset;

   mbcp_stream_if #(.payload_type(req_payload_type)) req_ch ();
   mbcp_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   mapped_bearer_context_parser uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // -------------------------------------------------------------------------
   // Parser model state: mirrors the byte walk of the block
   // -------------------------------------------------------------------------
   logic [2:0]  walk_phase;
   logic [7:0]  walk_context;
   logic [3:0]  walk_param;
   logic [3:0]  walk_params_left;
   logic [7:0]  walk_content_left;
   latch_type   walk_latch;

   rsp_payload_type expected_fields_q[$];
   logic [7:0]      element_bytes_q[$];

   int unsigned cycle_count     = 0;
   int unsigned mismatch_count  = 0;
   int unsigned bytes_accepted  = 0;
   int unsigned results_checked = 0;
   int unsigned truncated_count = 0;
   int unsigned elements_sent   = 0;
   int unsigned input_stalls    = 0;
   int unsigned held_cycles     = 0;

   // Sender burst shaping
   int unsigned    burst_left = 0;
   bit             tx_gaps_on = 1'b0;

   // Receiver stall shaping; a long hold starts whenever hold_requests moves
   rx_pattern_type rx_pattern    = RX_ALWAYS;
   int unsigned    hold_requests = 0;
   int unsigned    hold_seen     = 0;
   int unsigned    hold_left     = 0;
   int unsigned    rx_phase      = 0;

   function automatic void walk_reset();
      walk_phase        = KIND_IDENT;
      walk_context      = '0;
      walk_param        = '0;
      walk_params_left  = '0;
      walk_content_left = '0;
      walk_latch        = '0;
   endfunction

   // Close one parameter: move on to the next one or to a fresh context
   function automatic logic [2:0] walk_param_done();
      walk_params_left = walk_params_left - 4'd1;
      return (walk_params_left != 4'd0) ? KIND_PID : KIND_IDENT;
   endfunction

   // Advance the model by one byte and return the tagged result it yields
   function automatic rsp_payload_type predict_field(input logic [7:0] data,
                                                     input logic last);
      rsp_payload_type r;
      logic [2:0]      nxt;
      r            = '0;
      nxt          = KIND_IDENT;
      r.field_kind = walk_phase;
      case (walk_phase)
         KIND_IDENT: begin
            if (walk_context != CONTEXT_MAX) walk_context = walk_context + 8'd1;
            walk_latch                 = '0;
            walk_param                 = '0;
            walk_params_left           = '0;
            walk_content_left          = '0;
            walk_latch.bearer_identity = data[7:4];
            nxt                        = KIND_LEN_HI;
         end
         KIND_LEN_HI: begin
            walk_latch.context_length = {data, 8'h00};
            nxt                       = KIND_LEN_LO;
         end
         KIND_LEN_LO: begin
            walk_latch.context_length[7:0] = data;
            nxt                            = KIND_FLAGS;
         end
         KIND_FLAGS: begin
            walk_latch.operation_code = data[7:6];
            walk_latch.e_flag         = data[4];
            walk_latch.param_count    = data[3:0];
            walk_params_left          = data[3:0];
            nxt = (data[3:0] != 4'd0) ? KIND_PID : KIND_IDENT;
         end
         KIND_PID: begin
            walk_param                  = walk_param + 4'd1;
            walk_latch.param_identifier = data;
            walk_latch.param_length     = '0;
            nxt                         = KIND_PLEN;
         end
         KIND_PLEN: begin
            walk_latch.param_length = data;
            walk_content_left       = data;
            nxt = (data != 8'd0) ? KIND_CONTENT : walk_param_done();
         end
         default: begin
            r.field_kind      = KIND_CONTENT;
            walk_content_left = walk_content_left - 8'd1;
            nxt = (walk_content_left != 8'd0) ? KIND_CONTENT : walk_param_done();
         end
      endcase
      walk_phase         = nxt;
      r.context_number   = walk_context;
      r.param_number     = walk_param;
      r.bearer_identity  = walk_latch.bearer_identity;
      r.operation_code   = walk_latch.operation_code;
      r.e_flag           = walk_latch.e_flag;
      r.param_count      = walk_latch.param_count;
      r.context_length   = walk_latch.context_length;
      r.param_identifier = walk_latch.param_identifier;
      r.param_length     = walk_latch.param_length;
      r.truncated        = last && (nxt != KIND_IDENT);
      if (r.truncated) truncated_count++;
      // The last byte always returns the parser to its reset state
      if (last) walk_reset();
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Clock, watchdog
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF) clock = ~clock;
   end

   // Abort a run that stops making progress
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding",
                  $time, cycle_count, expected_fields_q.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: own stall pattern, plus a long hold counted here on request
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rx_phase <= (rx_phase == 4) ? 0 : rx_phase + 1;
      if (hold_seen != hold_requests) begin
         hold_seen    <= hold_requests;
         hold_left    <= LONG_HOLD - 1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         case (rx_pattern)
            RX_ALWAYS:   rsp_ch.ready <= 1'b1;
            RX_RANDOM:   rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: rsp_ch.ready <= (rx_phase >= 2);
            default:     rsp_ch.ready <= ($urandom_range(0, 2) == 0);
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Scoreboard: predict on every accepted byte, check every accepted result
   // -------------------------------------------------------------------------
   task automatic check_field(input string name, input int unsigned exp_val,
                              input int unsigned act_val);
      if (exp_val != act_val) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d actual %0d",
                  $time, name, exp_val, act_val);
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset) begin
         // Count cycles in which the block pushes back on the sender
         if (req_ch.valid && !req_ch.ready) input_stalls++;
         if (!rsp_ch.ready) held_cycles++;
         if (req_ch.valid && req_ch.ready) begin
            bytes_accepted++;
            expected_fields_q.push_back(predict_field(req_ch.payload.data_byte,
                                                      req_ch.payload.last_byte));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (expected_fields_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result, expected none actual %h",
                        $time, got);
            end else begin
               want = expected_fields_q.pop_front();
               results_checked++;
               check_field("field_kind", want.field_kind, got.field_kind);
               check_field("context_number", want.context_number, got.context_number);
               check_field("param_number", want.param_number, got.param_number);
               check_field("bearer_identity", want.bearer_identity,
                           got.bearer_identity);
               check_field("operation_code", want.operation_code, got.operation_code);
               check_field("e_flag", want.e_flag, got.e_flag);
               check_field("param_count", want.param_count, got.param_count);
               check_field("context_length", want.context_length, got.context_length);
               check_field("param_identifier", want.param_identifier,
                           got.param_identifier);
               check_field("param_length", want.param_length, got.param_length);
               check_field("truncated", want.truncated, got.truncated);
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sender: offer one byte, wait for its transaction; gaps fall between bursts
   // -------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] data, input logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = tx_gaps_on ? $urandom_range(0, 6) : 0;
         // Drop valid for the gap, then pick up again at a later edge
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.payload <= {data, last};
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Send the first cut bytes of the queued element, marking the last of them
   task automatic send_element(input int cut);
      for (int i = 0; i < cut; i++) send_byte(element_bytes_q[i], i == cut - 1);
      elements_sent++;
   endtask

   // Append one bearer context with random content to the element queue
   task automatic append_context(input int max_params, input int max_len);
      int unsigned params;
      int unsigned plen;
      params = $urandom_range(0, max_params);
      element_bytes_q.push_back(8'($urandom_range(0, 255)));
      element_bytes_q.push_back(8'($urandom_range(0, 255)));
      element_bytes_q.push_back(8'($urandom_range(0, 255)));
      element_bytes_q.push_back({4'($urandom_range(0, 15)), params[3:0]});
      for (int p = 0; p < params; p++) begin
         plen = $urandom_range(0, max_len);
         element_bytes_q.push_back(8'($urandom_range(0, 255)));
         element_bytes_q.push_back(plen[7:0]);
         repeat (plen) element_bytes_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Context with no parameters ends on its flags byte; all-ones fields
   task automatic test_zero_param_context();
      element_bytes_q = '{8'hF0, 8'hFF, 8'hFF, 8'hD0};
      send_element(element_bytes_q.size());
   endtask

   // Two parameters, the first with zero length ending on its length byte
   task automatic test_parameter_walk();
      element_bytes_q = '{8'h0F, 8'h00, 8'h00, 8'h42,
                          8'hFF, 8'h00, 8'h00, 8'h02, 8'hAA, 8'h55};
      send_element(element_bytes_q.size());
   endtask

   // Delete operation with one parameter holding a single content byte
   task automatic test_single_param();
      element_bytes_q = '{8'h30, 8'h01, 8'h02, 8'h81, 8'h7E, 8'h01, 8'hC3};
      send_element(element_bytes_q.size());
   endtask

   // Last mark on an identity byte and inside the length: raise truncated
   task automatic test_truncation();
      element_bytes_q = '{8'hA0};
      send_element(1);
      element_bytes_q = '{8'h5A, 8'h12};
      send_element(2);
   endtask

   // Run past 255 contexts in one element so the context number saturates
   task automatic test_context_saturation();
      element_bytes_q.delete();
      repeat (SAT_CONTEXTS) append_context(0, 0);
      send_element(element_bytes_q.size());
   endtask

   // Hold off the receiver while the sender keeps offering back to back
   task automatic test_receiver_backpressure();
      tx_gaps_on = 1'b0;
      rx_pattern = RX_ALWAYS;
      element_bytes_q.delete();
      repeat (3) append_context(4, 6);
      hold_requests++;
      send_element(element_bytes_q.size());
   endtask

   // Mostly well-formed elements, some cut short, some pure noise
   task automatic test_random_elements();
      int unsigned sent;
      int unsigned pick;
      int unsigned cut;
      int unsigned max_params;
      int unsigned max_len;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         // Reshape the idling of both sides now and then
         if ($urandom_range(0, 3) == 0) begin
            tx_gaps_on = 1'($urandom_range(0, 1));
            rx_pattern = rx_pattern_type'($urandom_range(0, 3));
         end
         pick = $urandom_range(0, 9);
         element_bytes_q.delete();
         if (pick == 9) begin
            // Noise: random bytes with a random mark, closed by a last byte
            repeat ($urandom_range(1, 12))
               element_bytes_q.push_back(8'($urandom_range(0, 255)));
            for (int i = 0; i < element_bytes_q.size(); i++)
               send_byte(element_bytes_q[i],
                         ($urandom_range(0, 5) == 0) || (i == element_bytes_q.size() - 1));
            elements_sent++;
            sent += element_bytes_q.size();
         end else begin
            repeat ($urandom_range(1, 3)) begin
               max_params = ($urandom_range(0, 7) == 0) ? 15 : 4;
               max_len    = ($urandom_range(0, 29) == 0 && max_params == 4) ? 255 : 5;
               append_context(max_params, max_len);
            end
            cut = (pick >= 7) ? $urandom_range(1, element_bytes_q.size())
                              : element_bytes_q.size();
            send_element(cut);
            sent += cut;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      walk_reset();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_zero_param_context();
      test_parameter_walk();
      test_single_param();
      test_truncation();
      tx_gaps_on = 1'b1;
      rx_pattern = RX_RANDOM;
      test_context_saturation();
      test_receiver_backpressure();
      test_random_elements();

      // Stop offering, drain outstanding results, then let the bench idle
      req_ch.valid <= 1'b0;
      rx_pattern   = RX_ALWAYS;
      while (expected_fields_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d results from %0d bytes in %0d elements (%0d truncated)",
               results_checked, bytes_accepted, elements_sent, truncated_count);
      $display("Receiver stalled %0d cycles; input pushed back %0d cycles",
               held_cycles, input_stalls);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
